// File: sv/psvc_pkg.sv
// Package for the pausable scaled virtual clock: request codes, payload structs
// and fixed constants. Used by psvc_core and pausable_scaled_virtual_clock.
`default_nettype none

package psvc_pkg;

	typedef enum logic [2:0] {
		REQ_TICK  = 3'd0,
		REQ_SET   = 3'd1,
		REQ_STOP  = 3'd2,
		REQ_START = 3'd3,
		REQ_SPEED = 3'd4
	} req_code_t;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [31:0]        real_time_ms;
		logic [31:0]        new_time;
		logic signed [15:0] new_speed;
	} psvc_req_t;

	typedef struct packed {
		logic [31:0] virtual_time;
		logic        stopped;
	} psvc_rsp_t;

	// Speed is unsigned Q8.8; 256 is a speed of 1.0.
	localparam logic [15:0] SPEED_ONE  = 16'd256;
	localparam logic [15:0] SPEED_ZERO = 16'd0;
	localparam int          FRAC_BITS  = 8;

	localparam logic signed [15:0] NEST_MIN = 16'sh8000;
	localparam logic signed [15:0] NEST_MAX = 16'sh7FFF;

endpackage

`default_nettype wire

// File: sv/psvc_core.sv
// Clock state and the combinational update for one request.
// Depends on psvc_pkg for the request codes and payload structs.
`default_nettype none

module psvc_core import psvc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire psvc_req_t item,
	output psvc_rsp_t      rsp_next
);

	logic [31:0]        base_q, rebase_q, sampled_q;
	logic signed [15:0] nest_q;
	logic [15:0]        speed_q;

	logic [31:0]        base_d, rebase_d, sampled_d;
	logic signed [15:0] nest_d;
	logic [15:0]        speed_d;

	logic [31:0] elapsed;
	logic [47:0] product;
	logic [31:0] run_time;
	logic [31:0] cur_old;
	logic        old_stopped;
	logic [31:0] vt;

	// A tick samples the new reading first, so its elapsed time uses that
	// reading; every other request works from the stored sample.
	assign elapsed     = ((item.req_type == REQ_TICK) ? item.real_time_ms : sampled_q)
	                     - rebase_q;
	assign product     = {16'd0, elapsed} * {32'd0, speed_q};
	assign run_time    = base_q + product[FRAC_BITS +: 32];
	assign old_stopped = (nest_q != 16'sd0);
	assign cur_old     = old_stopped ? base_q : run_time;

	always_comb begin
		base_d    = base_q;
		rebase_d  = rebase_q;
		sampled_d = sampled_q;
		nest_d    = nest_q;
		speed_d   = speed_q;
		vt        = cur_old;
		unique case (item.req_type)
			REQ_TICK: begin
				sampled_d = item.real_time_ms;
			end
			REQ_SET: begin
				sampled_d = item.real_time_ms;
				rebase_d  = item.real_time_ms;
				base_d    = item.new_time;
				vt        = item.new_time;
			end
			REQ_STOP: begin
				if (!old_stopped) begin
					base_d = run_time;
				end
				if (nest_q != NEST_MIN) begin
					nest_d = nest_q - 16'sd1;
				end
				// Leaving the last nested stop resumes from the old sample.
				vt = (nest_d != 16'sd0) ? base_d : run_time;
			end
			REQ_START: begin
				if (nest_q != NEST_MAX) begin
					nest_d = nest_q + 16'sd1;
				end
				if (nest_d == 16'sd0) begin
					sampled_d = item.real_time_ms;
					rebase_d  = item.real_time_ms;
				end
				vt = base_q;
			end
			REQ_SPEED: begin
				sampled_d = item.real_time_ms;
				rebase_d  = item.real_time_ms;
				base_d    = cur_old;
				speed_d   = item.new_speed[15] ? SPEED_ZERO : item.new_speed;
			end
			default: begin
			end
		endcase
	end

	assign rsp_next.virtual_time = vt;
	assign rsp_next.stopped      = (nest_d != 16'sd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q    <= '0;
			rebase_q  <= '0;
			sampled_q <= '0;
			nest_q    <= '0;
			speed_q   <= SPEED_ONE;
		end else if (fire) begin
			base_q    <= base_d;
			rebase_q  <= rebase_d;
			sampled_q <= sampled_d;
			nest_q    <= nest_d;
			speed_q   <= speed_d;
		end
	end

`ifndef SYNTHESIS
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		!speed_q[15])
		else $error("speed register holds a negative value");
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!fire |=> $stable(nest_q) && $stable(base_q) && $stable(speed_q))
		else $error("clock state changed without a transaction");
	a_stop_flag: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> ((nest_q != 16'sd0) == $past(rsp_next.stopped)))
		else $error("stopped flag disagrees with nesting counter");
`endif

endmodule

`default_nettype wire

// File: sv/pausable_scaled_virtual_clock.sv
// Top level of the pausable scaled virtual clock: input register, handshake
// and result register around psvc_core. Depends on psvc_pkg and psvc_core.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (psvc_req_t)
//   result  | rsp_valid | rsp_stall | rsp (psvc_rsp_t)
//
// A transaction enters the input register when it is accepted and its result is
// registered in the result register once the result side is free; one transaction
// is accepted every cycle while no stall is held; the 32x16 multiply and add of
// the core sit between the input register and the result register.
// Reset clears the valid flags and loads speed 1.0 with a zero time base.
// A stall on the result side holds the result and, one stage back, the request.
`default_nettype none

module pausable_scaled_virtual_clock import psvc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_stall,
	input  wire psvc_req_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output psvc_rsp_t      rsp
);

	logic      valid_s1;
	psvc_req_t item_s1;
	logic      rsp_valid_q;
	psvc_rsp_t rsp_q;
	psvc_rsp_t rsp_next;
	logic      out_free;
	logic      advance;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign advance   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;

	psvc_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (advance),
		.item     (item_s1),
		.rsp_next (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			item_s1 <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_free) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !req_stall)
		else $error("request stalled with an empty input stage");
	a_advance_out: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> rsp_valid)
		else $error("advanced transaction produced no result");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled without a blocked result");
`endif

endmodule

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for pausable_scaled_virtual_clock: a queue-fed request driver,
// a result monitor and a transaction-level predictor of the virtual time base.
// Depends on psvc_pkg and the RTL of the block.
`default_nettype none

module testbench import psvc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 10;

	typedef struct {
		psvc_req_t   payload;
		int unsigned gap;
	} pending_t;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	psvc_req_t req       = '0;
	logic      req_stall;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	psvc_rsp_t rsp;

	pausable_scaled_virtual_clock dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predicted state of the clock, updated as each request transaction is accepted.
	logic [31:0]        vt_base    = '0;
	logic [31:0]        vt_rebase  = '0;
	logic [31:0]        vt_sampled = '0;
	logic signed [15:0] stop_depth = '0;
	logic [15:0]        speed_q8   = SPEED_ONE;

	pending_t    pending_reqs[$];
	psvc_rsp_t   expected_rsp[$];
	pending_t    cur;
	logic        have_cur   = 1'b0;
	int unsigned gap_left   = 0;
	int unsigned stall_left = 0;
	logic        quiet      = 1'b0;
	int          errors     = 0;
	int          n_sent     = 0;
	int          n_checked  = 0;
	int          idle_count = 0;
	logic [31:0] now_ms     = '0;
	int          gen_depth  = 0;

	function automatic logic [31:0] clock_now();
		logic [31:0] elapsed;
		logic [47:0] scaled;
		logic [47:0] shifted;
		if (stop_depth != 0)
			return vt_base;
		elapsed = vt_sampled - vt_rebase;
		scaled  = {16'd0, elapsed} * {32'd0, speed_q8};
		shifted = scaled >> FRAC_BITS;
		return vt_base + shifted[31:0];
	endfunction

	function automatic psvc_rsp_t apply_request(psvc_req_t r);
		psvc_rsp_t   o;
		logic [31:0] vnow;
		case (r.req_type)
			REQ_TICK: vt_sampled = r.real_time_ms;
			REQ_SET: begin
				vt_sampled = r.real_time_ms;
				vt_rebase  = r.real_time_ms;
				vt_base    = r.new_time;
			end
			REQ_STOP: begin
				// Freezing uses the last sampled time, not the reading carried by this stop.
				if (stop_depth == 0)
					vt_base = clock_now();
				if (stop_depth != NEST_MIN)
					stop_depth = stop_depth - 16'sd1;
			end
			REQ_START: begin
				if (stop_depth != NEST_MAX)
					stop_depth = stop_depth + 16'sd1;
				if (stop_depth == 0) begin
					vt_sampled = r.real_time_ms;
					vt_rebase  = r.real_time_ms;
				end
			end
			REQ_SPEED: begin
				vnow       = clock_now();
				vt_sampled = r.real_time_ms;
				vt_rebase  = r.real_time_ms;
				vt_base    = vnow;
				speed_q8   = r.new_speed[15] ? SPEED_ZERO : r.new_speed;
			end
			default: ;
		endcase
		o.virtual_time = clock_now();
		o.stopped      = (stop_depth != 0);
		return o;
	endfunction

	// Request driver: each queued transaction waits out its own gap before valid rises.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else if (!(req_valid && req_stall)) begin
			if (req_valid) begin
				expected_rsp.push_back(apply_request(req));
				n_sent++;
			end
			if (!have_cur && pending_reqs.size() != 0) begin
				cur      = pending_reqs.pop_front();
				gap_left = cur.gap;
				have_cur = 1'b1;
			end
			if (have_cur && gap_left == 0) begin
				req_valid <= 1'b1;
				req       <= cur.payload;
				have_cur  = 1'b0;
			end else begin
				req_valid <= 1'b0;
				if (have_cur)
					gap_left--;
			end
		end
	end

	// Result monitor: compares each delivered result with the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: virtual_time %h stopped %b",
						$time, rsp.virtual_time, rsp.stopped);
				end else begin
					psvc_rsp_t want;
					want = expected_rsp.pop_front();
					if (rsp.virtual_time !== want.virtual_time) begin
						errors++;
						$display("%0t: virtual_time expected %h actual %h",
							$time, want.virtual_time, rsp.virtual_time);
					end
					if (rsp.stopped !== want.stopped) begin
						errors++;
						$display("%0t: stopped expected %b actual %b",
							$time, want.stopped, rsp.stopped);
					end
					n_checked++;
				end
				stall_left = quiet ? 0 : $urandom_range(0, 9);
			end
			if (stall_left != 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_count = 0;
			else
				idle_count++;
			if (idle_count >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic queue_req(logic [2:0] code, logic [31:0] rt, logic [31:0] nt,
			logic [15:0] sp);
		pending_t p;
		p.payload.req_type     = code;
		p.payload.real_time_ms = rt;
		p.payload.new_time     = nt;
		p.payload.new_speed    = sp;
		p.gap                  = quiet ? 0 : $urandom_range(0, 9);
		pending_reqs.push_back(p);
	endtask

	function automatic logic [31:0] next_time();
		if ($urandom_range(0, 19) == 0)
			now_ms = $urandom;
		else
			now_ms = now_ms + $urandom_range(0, 3000);
		return now_ms;
	endfunction

	function automatic logic [15:0] pick_speed();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 1023));
			2: return SPEED_ONE;
			default: return 16'h8000 | 16'($urandom);
		endcase
	endfunction

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || have_cur || req_valid || expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Mostly balanced stop/start pairs so the clock spends time running, with
	// the other requests mixed in and random content throughout.
	task automatic random_items(int n);
		int pick;
		gen_depth = -int'(stop_depth);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				queue_req(REQ_TICK, next_time(), $urandom, 16'($urandom));
			end else if (pick < 50) begin
				queue_req(REQ_SET, next_time(), $urandom, 16'($urandom));
			end else if (pick < 75) begin
				if (gen_depth > 0 ? $urandom_range(0, 2) != 0 : $urandom_range(0, 4) == 0) begin
					queue_req(REQ_START, next_time(), $urandom, 16'($urandom));
					gen_depth--;
				end else begin
					queue_req(REQ_STOP, next_time(), $urandom, 16'($urandom));
					gen_depth++;
				end
			end else if (pick < 94) begin
				queue_req(REQ_SPEED, next_time(), $urandom, pick_speed());
			end else begin
				queue_req(3'(REQ_SPEED) + 3'($urandom_range(1, 3)), $urandom, $urandom,
					16'($urandom));
			end
		end
	endtask

	initial begin : stimulus
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		queue_req(REQ_TICK, 32'd1000, '1, 16'h7FFF);
		queue_req(REQ_SPEED, 32'd2000, '0, 16'h7FFF);
		// Largest elapsed time at the largest speed: the scaled product wraps.
		queue_req(REQ_TICK, 32'hFFFF_FFFF, $urandom, 16'($urandom));
		queue_req(REQ_SPEED, 32'h0000_0010, $urandom, 16'h8000);
		queue_req(REQ_TICK, 32'h0000_5000, $urandom, 16'($urandom));
		queue_req(REQ_SPEED, 32'h0000_5100, $urandom, 16'hFFFF);
		queue_req(REQ_SPEED, 32'h0000_5200, $urandom, 16'h0000);
		queue_req(REQ_SPEED, 32'h0000_5300, $urandom, 16'h0001);
		queue_req(REQ_TICK, 32'h0002_0000, $urandom, 16'($urandom));
		queue_req(REQ_SPEED, 32'h0002_0100, $urandom, SPEED_ONE);
		queue_req(REQ_SET, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'($urandom));
		// Real time wraps past zero and the virtual time wraps with it.
		queue_req(REQ_TICK, 32'h0000_0010, $urandom, 16'($urandom));
		queue_req(REQ_SET, 32'd100, 32'd0, 16'($urandom));
		queue_req(REQ_TICK, 32'd600, $urandom, 16'($urandom));
		queue_req(REQ_STOP, 32'd700, $urandom, 16'($urandom));
		queue_req(REQ_TICK, 32'd900, $urandom, 16'($urandom));
		queue_req(REQ_STOP, 32'd950, $urandom, 16'($urandom));
		queue_req(REQ_SPEED, 32'd1000, $urandom, 16'd512);
		queue_req(REQ_START, 32'd1100, $urandom, 16'($urandom));
		queue_req(REQ_START, 32'd1200, $urandom, 16'($urandom));
		queue_req(REQ_TICK, 32'd1300, $urandom, 16'($urandom));
		// A start with nothing to undo stops the clock; the next stop releases it.
		queue_req(REQ_START, 32'd1400, $urandom, 16'($urandom));
		queue_req(REQ_STOP, 32'd1500, $urandom, 16'($urandom));
		queue_req(REQ_TICK, 32'd1600, $urandom, 16'($urandom));
		for (int c = 1; c <= 3; c++)
			queue_req(3'(REQ_SPEED) + 3'(c), $urandom, $urandom, 16'($urandom));
		wait_idle();

		for (int chunk = 0; chunk < 4; chunk++) begin
			quiet = (chunk == 2);
			random_items(250);
			wait_idle();
		end
		quiet = 1'b0;

		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_rsp.size() != 0) begin
			errors += expected_rsp.size();
			$display("%0t: %0d results never arrived", $time, expected_rsp.size());
		end
		$display("Checked %0d results against %0d requests, including nested stops,",
			n_checked, n_sent);
		$display("clamped and extreme speeds, back-to-back traffic and time wraparound.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire

// File: pausable_scaled_virtual_clock.f
sv/psvc_pkg.sv
sv/psvc_core.sv
sv/pausable_scaled_virtual_clock.sv
dv/testbench.sv
